FILE: hdl/bmhe_pkg.sv
// Shared types and constants for the binary moment Hessian engine.
// Used by every module of the block; depends on nothing else.
package bmhe_pkg;

  localparam int unsigned WEIGHT_W   = 24;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned PROD_W     = 2 * SUM_W;
  localparam int unsigned OUT_W      = 51;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned RND_W      = PROD_W - FRAC_W;
  localparam int unsigned PAIR_W     = 8;
  localparam int unsigned LOAD_W     = 8;
  localparam int unsigned STRIDE_W   = 5;
  localparam int unsigned UBITS_W    = 4;
  localparam int unsigned STEP_W     = $clog2(PAIR_W);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned DBL_W      = 2;

  localparam logic [STRIDE_W-1:0] STRIDE_RST = 5'd8;
  localparam logic [UBITS_W-1:0]  UBITS_RST  = 4'd8;
  localparam logic [PROD_W-1:0]   ROUND_HALF = PROD_W'(64'd1 << (FRAC_W - 1));

  localparam logic [CFG_IDX_W-1:0] REG_PAIR_STRIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USED_BITS   = 2'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Accumulator control from the sequencer.
  typedef struct packed {
    logic clear;
    logic add;
    logic ok1;
    logic ok2;
  } acc_ctrl_t;

endpackage

FILE: hdl/bmhe_div.sv
// Two-lane restoring divider: splits both pair indices by the stride,
// one quotient bit per cycle. Depends on bmhe_pkg.
module bmhe_div import bmhe_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0][PAIR_W-1:0]        dividend_i,
  input  logic [STRIDE_W-1:0]           divisor_i,
  output logic                          done_o,
  output logic [1:0][PAIR_W-1:0]        quot_o,
  output logic [1:0][STRIDE_W-1:0]      rem_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [STEP_W-1:0]          step_q, step_d;
  logic [STRIDE_W-1:0]        div_q, div_d;
  logic [1:0][PAIR_W-1:0]     acc_q, acc_d;
  logic [1:0][STRIDE_W-1:0]   rem_q, rem_d;
  logic [1:0][STRIDE_W:0]     rem_sh;
  logic [1:0][STRIDE_W:0]     rem_nx;
  logic [1:0]                 fits;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_sh[l] = {rem_q[l], acc_q[l][PAIR_W-1]};
      fits[l]   = rem_sh[l] >= {1'b0, div_q};
      rem_nx[l] = fits[l] ? rem_sh[l] - {1'b0, div_q} : rem_sh[l];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    div_d  = div_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      div_d  = divisor_i;
      acc_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      for (int l = 0; l < 2; l++) begin
        // remainder stays below the divisor, so it fits the narrow register
        rem_d[l] = rem_nx[l][STRIDE_W-1:0];
        acc_d[l] = {acc_q[l][PAIR_W-2:0], fits[l]};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(PAIR_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q;
  assign rem_o  = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a run");

endmodule

FILE: hdl/bmhe_table.sv
// Weight table: one write port, one read port, registered read data.
// Depends on bmhe_pkg.
module bmhe_table import bmhe_pkg::*; #(
  parameter int unsigned ADDR_W = 8
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [ADDR_W-1:0]   wr_addr_i,
  input  logic [WEIGHT_W-1:0] wr_data_i,
  input  logic                rd_en_i,
  input  logic [ADDR_W-1:0]   rd_addr_i,
  output logic [WEIGHT_W-1:0] rd_data_o
);

  logic [WEIGHT_W-1:0] mem_q [2**ADDR_W];
  logic [WEIGHT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/bmhe_accum.sv
// Moment accumulators: pair sums and joint sum over the walked entries.
// Depends on bmhe_pkg.
module bmhe_accum import bmhe_pkg::*; #(
  parameter int unsigned MAX_BITS = 8
) (
  input  logic                clk_i,
  input  acc_ctrl_t           ctrl_i,
  input  logic [MAX_BITS-1:0] mask1_i,
  input  logic [MAX_BITS-1:0] mask2_i,
  input  logic [MAX_BITS-1:0] idx_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  output logic [SUM_W-1:0]    e1_o,
  output logic [SUM_W-1:0]    e2_o,
  output logic [SUM_W-1:0]    e12_o
);

  logic [SUM_W-1:0] e1_q, e1_d;
  logic [SUM_W-1:0] e2_q, e2_d;
  logic [SUM_W-1:0] e12_q, e12_d;
  logic [SUM_W-1:0] w_ext;
  logic             hit1, hit2;

  assign w_ext = SUM_W'(weight_i);
  assign hit1  = ctrl_i.ok1 && ((idx_i & mask1_i) == mask1_i);
  assign hit2  = ctrl_i.ok2 && ((idx_i & mask2_i) == mask2_i);

  always_comb begin
    e1_d  = e1_q;
    e2_d  = e2_q;
    e12_d = e12_q;
    if (ctrl_i.clear) begin
      e1_d  = '0;
      e2_d  = '0;
      e12_d = '0;
    end else if (ctrl_i.add) begin
      if (hit1) begin
        e1_d = e1_q + w_ext;
      end
      if (hit2) begin
        e2_d = e2_q + w_ext;
      end
      if (hit1 && hit2) begin
        e12_d = e12_q + w_ext;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e1_q  <= e1_d;
    e2_q  <= e2_d;
    e12_q <= e12_d;
  end

  assign e1_o  = e1_q;
  assign e2_o  = e2_q;
  assign e12_o = e12_q;

endmodule

FILE: hdl/binary_moment_hessian_engine_top.sv
// Load: table write only, one word per accepted load. Query: divide, then
// walk 2^used_bits table entries (used_bits capped at MAX_BITS, one table read
// each), then drain, multiply and finish. The input stays stalled from accept
// until the result is written, so the engine handles one query at a time.
// A full output register holds the finish step. Reset sets pair_stride and
// used_bits to 8; table contents are not cleared.
module binary_moment_hessian_engine_top import bmhe_pkg::*; #(
  parameter int unsigned MAX_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [LOAD_W-1:0]           load_address_i,
  input  logic [WEIGHT_W-1:0]         load_weight_i,
  input  logic [PAIR_W-1:0]           first_pair_i,
  input  logic [PAIR_W-1:0]           second_pair_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [OUT_W-1:0]     hessian_value_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_DRAIN,
    ST_MUL,
    ST_FIN
  } state_e;

  localparam logic [UBITS_W-1:0] MaxBitsC = UBITS_W'(MAX_BITS);

  state_e                    state_q;
  logic [STRIDE_W-1:0]       stride_q;
  logic [UBITS_W-1:0]        ubits_q;
  logic [MAX_BITS-1:0]       idx_q;
  logic                      rd_vld_q;
  logic [MAX_BITS-1:0]       rd_idx_q;
  logic [MAX_BITS-1:0]       mask1_q, mask2_q;
  logic                      ok1_q, ok2_q;
  logic [DBL_W-1:0]          dbl_q;
  logic [PROD_W-1:0]         prod_q;
  logic                      out_valid_q;
  logic signed [OUT_W-1:0]   out_q;

  logic                      in_acc;
  logic                      div_start;
  logic                      div_done;
  logic [1:0][PAIR_W-1:0]    div_in;
  logic [1:0][PAIR_W-1:0]    quot;
  logic [1:0][STRIDE_W-1:0]  rem;
  logic [STRIDE_W-1:0]       stride_eff;
  logic [UBITS_W-1:0]        nbits;
  logic [MAX_BITS-1:0]       last_idx;
  logic [MAX_BITS-1:0]       mask1_d, mask2_d;
  logic                      ok1_d, ok2_d;
  logic [DBL_W-1:0]          dbl_d;
  logic                      wr_en;
  logic                      rd_en;
  logic [WEIGHT_W-1:0]       rd_data;
  acc_ctrl_t                 acc_ctrl;
  logic [SUM_W-1:0]          e1, e2, e12;
  logic [PROD_W-1:0]         prod_rnd;
  logic [OUT_W-1:0]          diff;
  logic [OUT_W-1:0]          result;
  logic                      out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign div_start  = in_acc && (operation_i == OP_QUERY);
  assign wr_en      = in_acc && (operation_i == OP_LOAD);
  assign rd_en      = (state_q == ST_WALK);
  assign div_in     = {second_pair_i, first_pair_i};
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= STRIDE_RST;
      ubits_q  <= UBITS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PAIR_STRIDE: stride_q <= cfg_data_i[STRIDE_W-1:0];
        REG_USED_BITS:   ubits_q  <= cfg_data_i[UBITS_W-1:0];
        default: ;
      endcase
    end
  end

  assign stride_eff = (stride_q == '0) ? STRIDE_W'(1) : stride_q;
  assign nbits      = (ubits_q > MaxBitsC) ? MaxBitsC : ubits_q;

  // Bit positions to masks; a position at or past nbits kills the pair.
  always_comb begin
    for (int i = 0; i < MAX_BITS; i++) begin
      last_idx[i] = (UBITS_W'(i) < nbits);
      mask1_d[i]  = (quot[0] == PAIR_W'(i)) || (PAIR_W'(rem[0]) == PAIR_W'(i));
      mask2_d[i]  = (quot[1] == PAIR_W'(i)) || (PAIR_W'(rem[1]) == PAIR_W'(i));
    end
    ok1_d = (quot[0] < PAIR_W'(nbits)) && (PAIR_W'(rem[0]) < PAIR_W'(nbits));
    ok2_d = (quot[1] < PAIR_W'(nbits)) && (PAIR_W'(rem[1]) < PAIR_W'(nbits));
    dbl_d = DBL_W'(quot[0] != PAIR_W'(rem[0])) + DBL_W'(quot[1] != PAIR_W'(rem[1]));
  end

  bmhe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_in),
    .divisor_i  (stride_eff),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  bmhe_table #(
    .ADDR_W (MAX_BITS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (MAX_BITS'(load_address_i)),
    .wr_data_i (load_weight_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  assign acc_ctrl.clear = (state_q == ST_DIV) && div_done;
  assign acc_ctrl.add   = rd_vld_q;
  assign acc_ctrl.ok1   = ok1_q;
  assign acc_ctrl.ok2   = ok2_q;

  bmhe_accum #(
    .MAX_BITS (MAX_BITS)
  ) u_accum (
    .clk_i    (clk_i),
    .ctrl_i   (acc_ctrl),
    .mask1_i  (mask1_q),
    .mask2_i  (mask2_q),
    .idx_i    (rd_idx_q),
    .weight_i (rd_data),
    .e1_o     (e1),
    .e2_o     (e2),
    .e12_o    (e12)
  );

  // Round Q32.32 product to Q32.16, subtract from joint sum, apply doublings.
  assign prod_rnd = prod_q + ROUND_HALF;
  assign diff     = OUT_W'(e12) - OUT_W'(prod_rnd[PROD_W-1:FRAC_W]);
  assign result   = diff << dbl_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      mask1_q     <= '0;
      mask2_q     <= '0;
      ok1_q       <= 1'b0;
      ok2_q       <= 1'b0;
      dbl_q       <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      rd_vld_q <= rd_en;
      rd_idx_q <= idx_q;
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (div_start) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            mask1_q <= mask1_d;
            mask2_q <= mask2_d;
            ok1_q   <= ok1_d;
            ok2_q   <= ok2_d;
            dbl_q   <= dbl_d;
            idx_q   <= '0;
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (idx_q == last_idx) begin
            state_q <= ST_DRAIN;
          end else begin
            idx_q <= idx_q + MAX_BITS'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= e1 * e2;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_q   <= result;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hessian_value_o = out_q;

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> in_stall_o)
    else $error("query accepted but engine not busy");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result word raised outside finish");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide state");

endmodule
